/* hw/rtl/arat_pkg.sv */
package arat_pkg;

   localparam int LEVEL_W    = 17;
   localparam int THRESH_W   = 16;
   localparam int ID_W       = 8;
   localparam int ELAPSED_W  = 20;
   localparam int TIME_W     = 24;
   localparam int NEXT_W     = TIME_W + 1;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 24;

   localparam int MAX_REPEATS_DEFAULT = 16;
   localparam int RESULT_LIMIT        = 16;
   localparam int DIV_STEPS           = TIME_W;

   localparam logic [TIME_W-1:0] HELD_MAX = {TIME_W{1'b1}};

   localparam logic [THRESH_W-1:0] RESET_REPEAT_THRESHOLD = THRESH_W'(0);
   localparam logic [TIME_W-1:0]   RESET_MIN_INTERVAL     = TIME_W'(33000);
   localparam logic [TIME_W-1:0]   RESET_MAX_INTERVAL     = TIME_W'(300000);
   localparam logic [TIME_W-1:0]   RESET_RAMP_TIME        = TIME_W'(900000);

   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_THRESHOLD = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_INTERVAL     = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_INTERVAL     = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_TIME        = CSR_INDEX_W'(3);

   typedef struct packed {
      logic [ID_W-1:0]      control_id;
      logic [LEVEL_W-1:0]   level;
      logic [ELAPSED_W-1:0] elapsed;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]    repeat_id;
      logic [LEVEL_W-1:0] repeat_level;
      logic               last_of_run;
   } rsp_type;

endpackage

/* hw/rtl/ramped_auto_repeat_timer.sv */
// Ramped auto-repeat timer for one held control.
// The request channel carries one frame tick per transfer: the control's
// identifier, its level (Q1.16) and the microseconds since the last tick.
// The response channel carries the repeat events that the tick causes, up to
// the repeat cap, with last_of_run set on the final event of the tick.
// The configuration channel writes the threshold, the two intervals and the
// ramp time; it is always ready and should only be used while no tick is
// in flight. Unknown register indexes are ignored.
// A tick that causes no event is finished in the cycle it is taken, and
// the block is ready again on the next cycle. A tick that causes events
// passes through the multiply state, the shared shift-subtract divider and
// the state that selects the interval before its first event is offered.
// Events then follow one per cycle; a stalled receiver simply holds the
// current event and the block waits, taking no new tick.
// Reset (synchronous) restores the register defaults and clears the held
// timer, the repeat schedule and the remembered level.
module ramped_auto_repeat_timer #(
   parameter int MAX_REPEATS = arat_pkg::MAX_REPEATS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  arat_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output arat_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [arat_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [arat_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int CAP    = (MAX_REPEATS < arat_pkg::RESULT_LIMIT) ?
                           MAX_REPEATS : arat_pkg::RESULT_LIMIT;
   localparam int CNT_W  = $clog2(CAP + 1);
   localparam int STEP_W = $clog2(arat_pkg::DIV_STEPS);
   localparam int TW     = arat_pkg::TIME_W;
   localparam int NW     = arat_pkg::NEXT_W;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_SEL  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [arat_pkg::THRESH_W-1:0] thresh_ff, thresh_in;
   logic [TW-1:0] min_ff, min_in;
   logic [TW-1:0] max_ff, max_in;
   logic [TW-1:0] ramp_ff, ramp_in;

   logic [arat_pkg::LEVEL_W-1:0] prev_ff, prev_in;
   logic [TW-1:0] held_ff, held_in;
   logic [NW-1:0] next_ff, next_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [arat_pkg::ID_W-1:0]    id_ff, id_in;
   logic [arat_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic [TW-1:0] rem_ff, rem_in;
   logic [TW-1:0] quo_ff, quo_in;
   logic [TW-1:0] iv_ff, iv_in;

   logic          req_xfer, rsp_xfer;
   logic          change;
   logic [NW-1:0] sum;
   logic [TW-1:0] held_new;
   logic [NW-1:0] next_cur;
   logic [TW-1:0] held_less;
   logic          cond;
   logic [2*TW-1:0] product;
   logic [TW:0]   trial;
   logic          trial_ge;
   logic [NW-1:0] next_step;
   logic          last;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;

   // Tick arithmetic for the held timer and the repeat check.
   always_comb begin
      change    = (req_data.level != '0) != (prev_ff != '0);
      sum       = {1'b0, held_ff} + NW'(req_data.elapsed);
      held_new  = change ? '0 : ((sum > {1'b0, arat_pkg::HELD_MAX}) ?
                                 arat_pkg::HELD_MAX : sum[TW-1:0]);
      next_cur  = change ? {1'b0, max_ff} : next_ff;
      held_less = held_new - TW'(req_data.elapsed);
      cond      = (thresh_ff != '0)
                  && (req_data.level > arat_pkg::LEVEL_W'(thresh_ff))
                  && (held_new != '0)
                  && ({1'b0, held_less} < next_cur);
   end

   // Shared datapath: one multiplier, one restoring divider step, one adder.
   assign product  = (2*TW)'(held_ff) * (2*TW)'(max_ff - min_ff);
   assign trial    = {rem_ff, quo_ff[TW-1]};
   assign trial_ge = (trial >= {1'b0, ramp_ff});
   assign next_step = next_ff + {1'b0, iv_ff};
   assign last = (count_ff == CNT_W'(CAP - 1)) || ({1'b0, held_ff} < next_step);

   assign rsp_data.repeat_id    = id_ff;
   assign rsp_data.repeat_level = level_ff;
   assign rsp_data.last_of_run  = last;

   always_comb begin
      state_in  = state_ff;
      thresh_in = thresh_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      ramp_in   = ramp_ff;
      prev_in   = prev_ff;
      held_in   = held_ff;
      next_in   = next_ff;
      count_in  = count_ff;
      step_in   = step_ff;
      id_in     = id_ff;
      level_in  = level_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      iv_in     = iv_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            arat_pkg::CSR_REPEAT_THRESHOLD: thresh_in = csr_data[arat_pkg::THRESH_W-1:0];
            arat_pkg::CSR_MIN_INTERVAL:     min_in    = csr_data[TW-1:0];
            arat_pkg::CSR_MAX_INTERVAL:     max_in    = csr_data[TW-1:0];
            arat_pkg::CSR_RAMP_TIME:        ramp_in   = csr_data[TW-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               prev_in  = req_data.level;
               held_in  = held_new;
               next_in  = next_cur;
               id_in    = req_data.control_id;
               level_in = req_data.level;
               count_in = '0;
               if (cond && ({1'b0, held_new} >= next_cur)) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            rem_in   = product[2*TW-1:TW];
            quo_in   = product[TW-1:0];
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Quotient bits shift in from the bottom as dividend bits leave the top.
            rem_in  = trial_ge ? TW'(trial - {1'b0, ramp_ff}) : trial[TW-1:0];
            quo_in  = {quo_ff[TW-2:0], trial_ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(arat_pkg::DIV_STEPS - 1)) begin
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            priority if (min_ff >= max_ff) begin
               iv_in = max_ff;
            end else if ((ramp_ff == '0) || (held_ff >= ramp_ff)) begin
               iv_in = min_ff;
            end else begin
               iv_in = max_ff - quo_ff;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               if (last) begin
                  // When the cap cuts the run short, the missed repeats are dropped.
                  next_in  = ({1'b0, held_ff} >= next_step) ?
                             ({1'b0, held_ff} + {1'b0, iv_ff}) : next_step;
                  state_in = ST_IDLE;
               end else begin
                  next_in  = next_step;
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         thresh_ff <= arat_pkg::RESET_REPEAT_THRESHOLD;
         min_ff    <= arat_pkg::RESET_MIN_INTERVAL;
         max_ff    <= arat_pkg::RESET_MAX_INTERVAL;
         ramp_ff   <= arat_pkg::RESET_RAMP_TIME;
         prev_ff   <= '0;
         held_ff   <= '0;
         next_ff   <= '0;
         count_ff  <= '0;
         step_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         thresh_ff <= thresh_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
         ramp_ff   <= ramp_in;
         prev_ff   <= prev_in;
         held_ff   <= held_in;
         next_ff   <= next_in;
         count_ff  <= count_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      level_ff <= level_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      iv_ff    <= iv_in;
   end

endmodule

/* hw/rtl/arat_checker.sv */
module arat_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input arat_pkg::rsp_type                rsp_data
);

   // A stalled event must be held unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled repeat event changed or dropped");

   // The block never takes a tick while events are still being offered.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("tick taken while an event is pending");

   // Events of one run follow back to back until the one marked last.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_of_run |=> rsp_valid)
      else $error("run ended without a last event");

   // After the last event of a run the block is ready for the next tick.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_of_run |=> req_ready && !rsp_valid)
      else $error("block not ready after the last event");

endmodule

bind ramped_auto_repeat_timer arat_checker u_arat_checker (.*);
